@@ src/csr_graph_edge_store_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef CSR_GRAPH_EDGE_STORE_UNIT_MACROS_SVH
`define CSR_GRAPH_EDGE_STORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSR_GES_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CSR_GES_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/csr_ges_pkg.sv @@
// Types and codes shared by the CSR graph edge store modules.
`timescale 1ns / 1ps
package csr_ges_pkg;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_APPEND = 3'd1,
		OP_FINISH = 3'd2,
		OP_INSERT = 3'd3,
		OP_QUERY  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_LAST_VERTEX    = 1'b0,
		REG_DECLARED_EDGES = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_QCALC,
		S_IPOS,
		S_SHIFT,
		S_BUMP,
		S_RESP
	} state_t;

	localparam int IN_BITS  = 64;
	localparam int OUT_BITS = 56;

	typedef struct packed {
		logic    clr_step;
		logic    capture;
		logic    off_rd;
		logic    start_wr;
		logic    append_wr;
		logic    finish_wr;
		logic    q_calc;
		logic    shift_init;
		logic    shift_step;
		logic    place_wr;
		logic    bump_init;
		logic    bump_step;
		logic    res_load;
		logic    res_query;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic vx_bad;
		logic ap_full;
		logic ec_full;
		logic fin_over;
		logic q_bad;
		logic shift_done;
		logic bump_done;
		logic out_free;
		op_t  opcode;
	} stat_t;

endpackage

@@ src/csr_ges_ctrl.sv @@
// Controller state machine sequencing each operation through the datapath.
`timescale 1ns / 1ps
module csr_ges_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  csr_ges_pkg::stat_t  stat,
	output csr_ges_pkg::cmd_t   cmd
);

	csr_ges_pkg::state_t  state_q, state_d;
	csr_ges_pkg::status_t st_q, st_d;
	logic                 qry_q, qry_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csr_ges_pkg::S_CLEAR;
			st_q    <= csr_ges_pkg::ST_OK;
			qry_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			qry_q   <= qry_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		st_d     = st_q;
		qry_d    = qry_q;
		s_tready = 1'b0;
		unique case (state_q)
			csr_ges_pkg::S_CLEAR: begin
				if (stat.clr_done) begin
					state_d = csr_ges_pkg::S_IDLE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			csr_ges_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = csr_ges_pkg::S_EXEC;
				end
			end
			csr_ges_pkg::S_EXEC: begin
				qry_d   = 1'b0;
				st_d    = csr_ges_pkg::ST_OK;
				state_d = csr_ges_pkg::S_RESP;
				case (stat.opcode)
					csr_ges_pkg::OP_START: begin
						if (stat.vx_bad) begin
							st_d = csr_ges_pkg::ST_RANGE;
						end else begin
							cmd.start_wr = 1'b1;
						end
					end
					csr_ges_pkg::OP_APPEND: begin
						if (stat.ap_full) begin
							st_d = csr_ges_pkg::ST_FULL;
						end else begin
							cmd.append_wr = 1'b1;
						end
					end
					csr_ges_pkg::OP_FINISH: begin
						cmd.finish_wr = 1'b1;
						if (stat.fin_over) begin
							st_d = csr_ges_pkg::ST_FULL;
						end
					end
					csr_ges_pkg::OP_INSERT: begin
						if (stat.vx_bad) begin
							st_d = csr_ges_pkg::ST_RANGE;
						end else if (stat.ec_full) begin
							st_d = csr_ges_pkg::ST_FULL;
						end else begin
							cmd.off_rd = 1'b1;
							state_d    = csr_ges_pkg::S_IPOS;
						end
					end
					csr_ges_pkg::OP_QUERY: begin
						if (stat.vx_bad) begin
							st_d = csr_ges_pkg::ST_RANGE;
						end else begin
							cmd.off_rd = 1'b1;
							state_d    = csr_ges_pkg::S_QCALC;
						end
					end
					default: begin
						st_d = csr_ges_pkg::ST_RANGE;
					end
				endcase
			end
			csr_ges_pkg::S_QCALC: begin
				cmd.q_calc = 1'b1;
				qry_d      = 1'b1;
				state_d    = csr_ges_pkg::S_RESP;
			end
			csr_ges_pkg::S_IPOS: begin
				cmd.shift_init = 1'b1;
				state_d        = csr_ges_pkg::S_SHIFT;
			end
			csr_ges_pkg::S_SHIFT: begin
				if (stat.shift_done) begin
					cmd.place_wr  = 1'b1;
					cmd.bump_init = 1'b1;
					state_d       = csr_ges_pkg::S_BUMP;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			csr_ges_pkg::S_BUMP: begin
				cmd.bump_step = 1'b1;
				if (stat.bump_done) begin
					st_d    = csr_ges_pkg::ST_OK;
					state_d = csr_ges_pkg::S_RESP;
				end
			end
			csr_ges_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.res_load  = 1'b1;
					cmd.res_query = qry_q;
					if (qry_q) begin
						cmd.res_status = stat.q_bad ? csr_ges_pkg::ST_RANGE
							: csr_ges_pkg::ST_OK;
					end else begin
						cmd.res_status = st_q;
					end
					state_d = csr_ges_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = csr_ges_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ src/csr_ges_dp.sv @@
// Datapath: row offset and edge memories, pointers, shift/bump counters, output register.
`timescale 1ns / 1ps
module csr_ges_dp #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 4096,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csr_ges_pkg::cmd_t                   cmd,
	output csr_ges_pkg::stat_t                  stat,
	input  logic [csr_ges_pkg::IN_BITS-1:0]     s_tdata,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [12:0]                         cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [csr_ges_pkg::OUT_BITS-1:0]    m_tdata
);

	localparam int OD  = MAX_VERTICES + 1;
	localparam int OAW = $clog2(MAX_VERTICES + 1);
	localparam int IW  = $clog2(MAX_VERTICES + 2);
	localparam int OW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = $clog2(MAX_EDGES);
	localparam int EW  = 8 + WEIGHT_BITS;

	// configuration
	logic [7:0]  last_vertex_q;
	logic [12:0] declared_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_vertex_q <= 8'd255;
			declared_q    <= 13'd0;
		end else if (cfg_we) begin
			unique case (csr_ges_pkg::reg_idx_t'(cfg_index))
				csr_ges_pkg::REG_LAST_VERTEX:    last_vertex_q <= cfg_data[7:0];
				csr_ges_pkg::REG_DECLARED_EDGES: declared_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured item
	csr_ges_pkg::op_t op_q;
	logic [7:0]       vx_q;
	logic [7:0]       tg_q;
	logic [31:0]      wt_q;
	logic [11:0]      k_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= csr_ges_pkg::op_t'(s_tdata[2:0]);
			vx_q <= s_tdata[10:3];
			tg_q <= s_tdata[18:11];
			wt_q <= s_tdata[50:19];
			k_q  <= s_tdata[62:51];
		end
	end

	// derived values
	int                        lv_i;
	logic [IW-1:0]             lv;
	logic [IW-1:0]             lv1;
	logic                      vx_bad;
	logic                      fin_over;
	logic [OW-1:0]             total;
	logic signed [63:0]        wt_ext;
	logic [WEIGHT_BITS-1:0]    wt_st;

	always_comb begin
		lv_i     = (32'(last_vertex_q) > 32'(MAX_VERTICES - 1)) ? MAX_VERTICES - 1
			: 32'(last_vertex_q);
		lv       = IW'(lv_i);
		lv1      = lv + IW'(1);
		vx_bad   = 32'(vx_q) > 32'(lv);
		fin_over = 32'(declared_q) > 32'(MAX_EDGES);
		total    = fin_over ? OW'(MAX_EDGES) : OW'(declared_q);
		wt_ext   = 64'(signed'(wt_q));
		wt_st    = WEIGHT_BITS'(wt_ext);
	end

	// pointers and counters
	logic [OW-1:0]  ap_q, ec_q;
	logic [IW-1:0]  clr_q;
	logic [OW-1:0]  j_q, pos_q, swaddr_q;
	logic           spend_q;
	logic [IW-1:0]  i_q;
	logic           bpend_q;
	logic [OAW-1:0] baddr_q;
	logic [OW-1:0]  deg_q;
	logic           qbad_q;

	// row offset memory: two read ports, one write port
	logic [OW-1:0]  off_mem [OD];
	logic [OW-1:0]  rda_q, rdb_q;
	logic           i_le;
	logic           offa_en;
	logic [OAW-1:0] offa_addr;
	logic [OAW-1:0] offb_addr;
	logic           off_we;
	logic [OAW-1:0] off_wa;
	logic [OW-1:0]  off_wd;
	logic [OW-1:0]  bump_val;

	always_comb begin
		i_le      = i_q <= lv1;
		offa_en   = cmd.off_rd | (cmd.bump_step & i_le);
		offa_addr = cmd.off_rd ? OAW'(vx_q) : OAW'(i_q);
		offb_addr = OAW'(32'(vx_q) + 1);
		bump_val  = (32'(rda_q) < 32'(MAX_EDGES)) ? rda_q + OW'(1) : rda_q;
		off_we    = 1'b1;
		off_wa    = baddr_q;
		off_wd    = bump_val;
		if (cmd.clr_step) begin
			off_wa = OAW'(clr_q);
			off_wd = '0;
		end else if (cmd.start_wr) begin
			off_wa = OAW'(vx_q);
			off_wd = ap_q;
		end else if (cmd.finish_wr) begin
			off_wa = OAW'(lv1);
			off_wd = total;
		end else if (!bpend_q) begin
			off_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_wa] <= off_wd;
		end
		if (offa_en) begin
			rda_q <= off_mem[offa_addr];
		end
		if (cmd.off_rd) begin
			rdb_q <= off_mem[offb_addr];
		end
	end

	// edge memory: target in the high bits, weight in the low bits
	logic [EW-1:0]  edge_mem [MAX_EDGES];
	logic [EW-1:0]  erd_q;
	logic           j_gt;
	logic           erd_en;
	logic [EAW-1:0] erd_addr;
	logic           e_we;
	logic [EAW-1:0] e_wa;
	logic [EW-1:0]  e_wd;
	logic [OW-1:0]  q_deg;
	logic [31:0]    q_idx;
	logic           q_bad;
	logic [OW-1:0]  pos_new;

	always_comb begin
		j_gt    = j_q > pos_q;
		pos_new = (rdb_q > ec_q) ? ec_q : rdb_q;
		q_deg   = (rdb_q >= rda_q) ? rdb_q - rda_q : '0;
		q_idx   = 32'(rda_q) + 32'(k_q);
		q_bad   = (32'(k_q) >= 32'(q_deg)) || (q_idx >= 32'(MAX_EDGES));
		erd_en  = cmd.q_calc | (cmd.shift_step & j_gt);
		erd_addr = cmd.q_calc ? EAW'(q_idx) : EAW'(j_q - OW'(1));
		e_we    = 1'b1;
		e_wa    = EAW'(swaddr_q);
		e_wd    = erd_q;
		if (cmd.append_wr) begin
			e_wa = EAW'(ap_q);
			e_wd = {tg_q, wt_st};
		end else if (cmd.place_wr) begin
			e_wa = EAW'(pos_q);
			e_wd = {tg_q, wt_st};
		end else if (!spend_q) begin
			e_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			edge_mem[e_wa] <= e_wd;
		end
		if (erd_en) begin
			erd_q <= edge_mem[erd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_q    <= '0;
			ec_q    <= '0;
			clr_q   <= '0;
			spend_q <= 1'b0;
			bpend_q <= 1'b0;
			qbad_q  <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cmd.append_wr) begin
				ap_q <= ap_q + OW'(1);
			end
			if (cmd.finish_wr) begin
				ec_q <= total;
			end else if (cmd.place_wr) begin
				ec_q <= ec_q + OW'(1);
			end
			if (cmd.shift_init) begin
				spend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				spend_q <= j_gt;
			end
			if (cmd.bump_init) begin
				bpend_q <= 1'b0;
			end else if (cmd.bump_step) begin
				bpend_q <= i_le;
			end
			if (cmd.q_calc) begin
				qbad_q <= q_bad;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.shift_init) begin
			pos_q <= pos_new;
			j_q   <= ec_q;
		end else if (cmd.shift_step && j_gt) begin
			j_q      <= j_q - OW'(1);
			swaddr_q <= j_q;
		end
		if (cmd.bump_init) begin
			i_q <= IW'(32'(vx_q) + 1);
		end else if (cmd.bump_step && i_le) begin
			i_q     <= i_q + IW'(1);
			baddr_q <= OAW'(i_q);
		end
		if (cmd.q_calc) begin
			deg_q <= q_deg;
		end
	end

	// result register
	logic                             m_valid_q;
	logic [csr_ges_pkg::OUT_BITS-1:0] m_data_q;
	logic [12:0]                      r_deg;
	logic [7:0]                       r_nb;
	logic [31:0]                      r_wt;

	always_comb begin
		r_deg = cmd.res_query ? 13'(deg_q) : 13'd0;
		r_nb  = 8'd0;
		r_wt  = 32'd0;
		if (cmd.res_query && !qbad_q) begin
			r_nb = erd_q[EW-1:WEIGHT_BITS];
			r_wt = 32'(erd_q[WEIGHT_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			m_data_q <= {1'b0, r_wt, r_nb, r_deg, cmd.res_status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_comb begin
		stat.clr_done   = clr_q == IW'(MAX_VERTICES + 1);
		stat.vx_bad     = vx_bad;
		stat.ap_full    = 32'(ap_q) >= 32'(MAX_EDGES);
		stat.ec_full    = 32'(ec_q) >= 32'(MAX_EDGES);
		stat.fin_over   = fin_over;
		stat.q_bad      = qbad_q;
		stat.shift_done = !j_gt && !spend_q;
		stat.bump_done  = !i_le && !bpend_q;
		stat.out_free   = !m_valid_q || m_tready;
		stat.opcode     = op_q;
	end

endmodule

@@ src/csr_graph_edge_store_unit.sv @@
// Top level of the CSR graph edge store: controller plus datapath.
`timescale 1ns / 1ps
// Compressed sparse row graph store. One command per input transfer, one result
// transfer per command. After reset a clearing pass writes zero to all
// MAX_VERTICES+1 row offsets, one per cycle; s_tready stays low until the pass
// ends. Start row, append, finish, rejected and unknown commands go from transfer
// to result load through the execute state; query reads the offsets there, then
// its edge in the query state. Insert reads the offsets, then walks the edges above
// the insert point up one slot and bumps the last_vertex+1-vertex row offsets after
// the vertex: each walk goes one entry per cycle through the single write port of
// its memory, then drains its last write and sees the walk finished. A held result
// delays the result load. Write configuration only while no command is in flight.
module csr_graph_edge_store_unit #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 4096,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[2:0], vertex[10:3], target[18:11], weight[50:19], neighbor_index[62:51]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], degree[14:2], neighbor[22:15], neighbor_weight[54:23]
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	csr_ges_pkg::cmd_t  cmd;
	csr_ges_pkg::stat_t stat;

	csr_ges_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	csr_ges_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

@@ src/csr_ges_checker.sv @@
// Port-level checker for the CSR graph edge store, bound to the top level.
`timescale 1ns / 1ps
`include "csr_graph_edge_store_unit_macros.svh"
module csr_ges_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	`CSR_GES_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`CSR_GES_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second command taken while one in flight")
	`CSR_GES_ASSERT_IMP(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3, "undefined status code")
	`CSR_GES_ASSERT_IMP(a_full_no_data, m_tvalid && m_tdata[1:0] == csr_ges_pkg::ST_FULL, m_tdata[54:2] == 53'd0, "store-full result carries data")

endmodule

bind csr_graph_edge_store_unit csr_ges_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
